// ----- hw/rtl/lcs_pkg.sv -----
`default_nettype none

package lcs_pkg;

  // Request codes carried in the input tuser
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_EVICT  = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_REMOVE = 2'd3
  } req_t;

  // Fixed field widths at the ports
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned IN_TAG_W  = 20;
  localparam int unsigned WAY_OUT_W = 3;
  localparam int unsigned IN_DATA_W = 24;
  localparam int unsigned IN_USER_W = 2;

  // Associativity after reset
  localparam logic [CFG_W-1:0] CAP_RESET = 4'd8;

  // Result transaction, packed from the lowest bit up: success, way, evicted_tag
  typedef struct packed {
    logic [IN_TAG_W-1:0]  evicted_tag;
    logic [WAY_OUT_W-1:0] way;
    logic                 success;
  } res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lru_cache_set.sv -----
`default_nettype none

// Channel | Direction  | Ports                   | Contents
// --------+------------+-------------------------+--------------------------------------
// in      | slave      | in_tvalid/tready/tdata  | tdata: tag[19:0], zero pad [23:20]
//         |            | in_tuser                | tuser: req_type[1:0]
// out     | master     | out_tvalid/tready/tdata | tdata: success[0], way[3:1],
//         |            |                         |        evicted_tag[23:4]
// cfg     | write only | cfg_wen/cfg_wdata       | ways_in_use[3:0]
//
// One transaction a cycle is sustained while the result is not stalled: an
// accepted request sits in the input register, then one pass of tag compare
// and rank update writes the result register. Reset (rst_n low at a clock edge)
// clears valid bits, ranks, line count and both stage valids; stored tags
// are left alone. A stalled result holds the input register, and the input
// side stays ready while only the result waits.

module lru_cache_set
  import lcs_pkg::*;
#(
  parameter int unsigned WAYS     = 8,
  parameter int unsigned TAG_BITS = 20
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration
  input  wire logic                 cfg_wen,
  input  wire logic [CFG_W-1:0]     cfg_wdata,     // ways_in_use
  // request stream
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,      // tag, zero pad
  input  wire logic [IN_USER_W-1:0] in_tuser,      // req_type
  // result stream
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [$bits(res_t)-1:0]   out_tdata      // success, way, evicted_tag
);

  localparam int unsigned RANK_W = $clog2(WAYS);
  localparam int unsigned CNT_W  = $clog2(WAYS + 1);
  localparam int unsigned CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  // Set state
  logic [TAG_BITS-1:0] tag_r    [WAYS];
  logic [RANK_W-1:0]   rank_r   [WAYS];
  logic [RANK_W-1:0]   rank_nxt [WAYS];
  logic [WAYS-1:0]     valid_r, valid_nxt;
  logic [CNT_W-1:0]    line_count_r, line_count_nxt;
  logic [CFG_W-1:0]    ways_in_use_r;

  // Input register
  logic                s1_valid_r;
  req_t                s1_req_r;
  logic [TAG_BITS-1:0] s1_tag_r;

  // Result register
  logic out_tvalid_r;
  res_t out_data_r;

  logic advance, s1_fire;

  // Search results
  logic              hit_any, free_any, old_any;
  logic [RANK_W-1:0] hit_idx, free_idx, old_idx, drop_idx;
  logic [RANK_W-1:0] hit_rank, drop_rank, old_rank;
  logic [CMP_W-1:0]  cap, count_ext;
  logic              full;
  logic              do_promote, do_fill, do_drop;
  res_t              res;

  assign advance   = !out_tvalid_r || out_tready;
  assign s1_fire   = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // Capacity clamped to 1..WAYS
  always_comb begin
    cap = CMP_W'(ways_in_use_r);
    if (cap == '0) begin
      cap = CMP_W'(1);
    end else if (cap > CMP_W'(WAYS)) begin
      cap = CMP_W'(WAYS);
    end
    count_ext = CMP_W'(line_count_r);
    full      = (count_ext >= cap);
  end

  // Tag match, lowest free way, least recent way (rank count-1)
  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    old_any  = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    old_idx  = '0;
    old_rank = RANK_W'(line_count_r - 1'b1);
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (valid_r[i] && (tag_r[i] == s1_tag_r)) begin
        hit_any = 1'b1;
        hit_idx = RANK_W'(i);
      end
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = RANK_W'(i);
      end
      if (valid_r[i] && (rank_r[i] == old_rank)) begin
        old_any = 1'b1;
        old_idx = RANK_W'(i);
      end
    end
    drop_idx  = (s1_req_r == REQ_EVICT) ? old_idx : hit_idx;
    hit_rank  = rank_r[hit_idx];
    drop_rank = rank_r[drop_idx];
  end

  // Request decode and result
  always_comb begin
    res        = '0;
    do_promote = 1'b0;
    do_fill    = 1'b0;
    do_drop    = 1'b0;
    case (s1_req_r)
      REQ_INSERT: begin
        if (hit_any) begin
          do_promote  = 1'b1;
          res.success = 1'b1;
          res.way     = WAY_OUT_W'(hit_idx);
        end else if (!full && free_any) begin
          do_fill     = 1'b1;
          res.success = 1'b1;
          res.way     = WAY_OUT_W'(free_idx);
        end
      end
      REQ_EVICT: begin
        if (full && old_any) begin
          do_drop         = 1'b1;
          res.success     = 1'b1;
          res.way         = WAY_OUT_W'(old_idx);
          res.evicted_tag = IN_TAG_W'(tag_r[old_idx]);
        end
      end
      REQ_LOOKUP: begin
        if (hit_any) begin
          res.success = 1'b1;
          res.way     = WAY_OUT_W'(hit_idx);
        end
      end
      REQ_REMOVE: begin
        if (hit_any) begin
          do_drop     = 1'b1;
          res.success = 1'b1;
          res.way     = WAY_OUT_W'(hit_idx);
        end
      end
      default: ;
    endcase
  end

  // Recency and valid update
  always_comb begin
    valid_nxt      = valid_r;
    line_count_nxt = line_count_r;
    for (int i = 0; i < WAYS; i++) begin
      rank_nxt[i] = rank_r[i];
    end
    if (s1_fire && do_promote) begin
      // lines newer than the hit age by one
      for (int i = 0; i < WAYS; i++) begin
        if (valid_r[i] && (RANK_W'(i) != hit_idx) && (rank_r[i] < hit_rank)) begin
          rank_nxt[i] = rank_r[i] + 1'b1;
        end
      end
      rank_nxt[hit_idx] = '0;
    end else if (s1_fire && do_fill) begin
      for (int i = 0; i < WAYS; i++) begin
        if (valid_r[i]) begin
          rank_nxt[i] = rank_r[i] + 1'b1;
        end
      end
      valid_nxt[free_idx] = 1'b1;
      rank_nxt[free_idx]  = '0;
      line_count_nxt      = line_count_r + 1'b1;
    end else if (s1_fire && do_drop) begin
      // lines older than the dropped one move up
      for (int i = 0; i < WAYS; i++) begin
        if (valid_r[i] && (rank_r[i] > drop_rank)) begin
          rank_nxt[i] = rank_r[i] - 1'b1;
        end
      end
      valid_nxt[drop_idx] = 1'b0;
      rank_nxt[drop_idx]  = '0;
      line_count_nxt      = line_count_r - 1'b1;
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_tvalid_r  <= 1'b0;
      valid_r       <= '0;
      line_count_r  <= '0;
      ways_in_use_r <= CAP_RESET;
      for (int i = 0; i < WAYS; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_tvalid_r <= s1_valid_r;
      end
      if (cfg_wen) begin
        ways_in_use_r <= cfg_wdata;
      end
      valid_r      <= valid_nxt;
      line_count_r <= line_count_nxt;
      for (int i = 0; i < WAYS; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_req_r <= req_t'(in_tuser);
      s1_tag_r <= TAG_BITS'(in_tdata[IN_TAG_W-1:0]);
    end
    if (advance) begin
      out_data_r <= res;
    end
    if (s1_fire && do_fill) begin
      tag_r[free_idx] <= s1_tag_r;
    end
  end

  // Checks
  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'($countones(valid_r)) == line_count_r)
    else $error("line count differs from number of valid ways");

  a_evict_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && (s1_req_r == REQ_EVICT) && res.success)
      |=> (line_count_r == $past(line_count_r) - 1'b1))
    else $error("successful evict did not reduce the line count");

  a_fail_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_data_r.success)
      |-> ((out_data_r.way == '0) && (out_data_r.evicted_tag == '0)))
    else $error("failed request returned non-zero way or tag");

  a_fill_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && do_fill) |-> (count_ext < cap))
    else $error("line filled into a full set");

endmodule

`default_nettype wire
